// ===== hw/rtl/jddm_pkg.sv =====
// Shared widths, register codes, configuration struct and reset values
// for the joystick differential drive mixer. No dependencies.
`default_nettype none

package jddm_pkg;

   localparam int unsigned AXIS_W     = 16;  // joystick axis and divisor width
   localparam int unsigned DRV_W      = 16;  // signed drive outputs
   localparam int unsigned DMAX_W     = 15;
   localparam int unsigned THR_W      = 15;
   localparam int unsigned PROD_W     = 31;  // 16 x 15 products
   localparam int unsigned DIVD_W     = 32;  // divider dividend
   localparam int unsigned QUO_W      = 17;  // divider quotient, saturating
   localparam int unsigned FRAC_W     = 15;  // Q1.15 steering
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AXIS_CENTRE,
      CSR_DRIVE_MAX,
      CSR_DRIVE_MIN,
      CSR_SPIN_THR
   } csr_idx_type;

   typedef struct packed {
      logic [AXIS_W-1:0]        centre;     // zero already mapped to one
      logic [DMAX_W-1:0]        drive_max;
      logic signed [DRV_W-1:0]  drive_min;
      logic [THR_W-1:0]         spin_thr;
   } cfg_type;

   localparam logic [AXIS_W-1:0]       CENTRE_RST    = 16'd32767;
   localparam logic [DMAX_W-1:0]       DRIVE_MAX_RST = 15'd1000;
   localparam logic signed [DRV_W-1:0] DRIVE_MIN_RST = -16'sd1000;
   localparam logic [THR_W-1:0]        SPIN_THR_RST  = 15'd100;

endpackage

`default_nettype wire

// ===== hw/rtl/jddm_csr.sv =====
// Configuration registers of the drive mixer, written through the csr channel.
// Depends on jddm_pkg.
`default_nettype none

module jddm_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [jddm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [jddm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output      jddm_pkg::cfg_type                     cfg
);

   logic [jddm_pkg::AXIS_W-1:0]       centre_ff,    centre_in;
   logic [jddm_pkg::DMAX_W-1:0]       drive_max_ff, drive_max_in;
   logic signed [jddm_pkg::DRV_W-1:0] drive_min_ff, drive_min_in;
   logic [jddm_pkg::THR_W-1:0]        spin_thr_ff,  spin_thr_in;
   jddm_pkg::csr_idx_type             idx;

   assign csr_ready = 1'b1;
   assign idx       = jddm_pkg::csr_idx_type'(csr_index);

   always_comb begin
      centre_in    = centre_ff;
      drive_max_in = drive_max_ff;
      drive_min_in = drive_min_ff;
      spin_thr_in  = spin_thr_ff;
      if (csr_valid && csr_ready) begin
         unique case (idx)
            jddm_pkg::CSR_AXIS_CENTRE: centre_in    = csr_wdata;
            jddm_pkg::CSR_DRIVE_MAX:   drive_max_in = csr_wdata[jddm_pkg::DMAX_W-1:0];
            jddm_pkg::CSR_DRIVE_MIN:   drive_min_in = signed'(csr_wdata);
            jddm_pkg::CSR_SPIN_THR:    spin_thr_in  = csr_wdata[jddm_pkg::THR_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff    <= jddm_pkg::CENTRE_RST;
         drive_max_ff <= jddm_pkg::DRIVE_MAX_RST;
         drive_min_ff <= jddm_pkg::DRIVE_MIN_RST;
         spin_thr_ff  <= jddm_pkg::SPIN_THR_RST;
      end else begin
         centre_ff    <= centre_in;
         drive_max_ff <= drive_max_in;
         drive_min_ff <= drive_min_in;
         spin_thr_ff  <= spin_thr_in;
      end
   end

   // a centre of zero divides as one
   assign cfg.centre    = (centre_ff == '0) ? jddm_pkg::AXIS_W'(1) : centre_ff;
   assign cfg.drive_max = drive_max_ff;
   assign cfg.drive_min = drive_min_ff;
   assign cfg.spin_thr  = spin_thr_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/jddm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with saturation flag.
// Lanes share the divisor; a side word travels with valid. Depends on jddm_pkg.
`default_nettype none

module jddm_div #(
   parameter int LANES  = 1,
   parameter int SIDE_W = 1
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          in_valid,
   input  wire logic [LANES-1:0][jddm_pkg::DIVD_W-1:0]        in_dividend,
   input  wire logic [jddm_pkg::AXIS_W-1:0]                   divisor,
   input  wire logic [SIDE_W-1:0]                             in_side,
   output      logic                                          out_valid,
   output      logic [LANES-1:0][jddm_pkg::QUO_W-1:0]         out_quotient,
   output      logic [LANES-1:0]                              out_over,
   output      logic [SIDE_W-1:0]                             out_side
);

   localparam int QW    = jddm_pkg::QUO_W;
   localparam int DW    = jddm_pkg::DIVD_W;
   localparam int REM_W = jddm_pkg::AXIS_W;

   logic                            valid_ff [0:QW];
   logic                            valid_in [0:QW];
   logic [SIDE_W-1:0]               side_ff  [0:QW];
   logic [SIDE_W-1:0]               side_in  [0:QW];
   logic [LANES-1:0]                over_ff  [0:QW];
   logic [LANES-1:0]                over_in  [0:QW];
   logic [LANES-1:0][REM_W-1:0]     rem_ff   [0:QW];
   logic [LANES-1:0][REM_W-1:0]     rem_in   [0:QW];
   logic [LANES-1:0][QW-1:0]        low_ff   [0:QW];
   logic [LANES-1:0][QW-1:0]        low_in   [0:QW];
   logic [LANES-1:0][QW-1:0]        quo_ff   [0:QW];
   logic [LANES-1:0][QW-1:0]        quo_in   [0:QW];

   always_comb begin
      logic [REM_W:0] trial;
      logic [REM_W:0] diff;
      logic           ge;

      // entry: quotient of 2^QW or more is flagged as overflow
      valid_in[0] = in_valid;
      side_in[0]  = in_side;
      for (int l = 0; l < LANES; l++) begin
         over_in[0][l] = REM_W'(in_dividend[l][DW-1:QW]) >= divisor;
         rem_in[0][l]  = REM_W'(in_dividend[l][DW-1:QW]);
         low_in[0][l]  = in_dividend[l][QW-1:0];
         quo_in[0][l]  = '0;
      end

      for (int k = 0; k < QW; k++) begin
         valid_in[k+1] = valid_ff[k];
         side_in[k+1]  = side_ff[k];
         for (int l = 0; l < LANES; l++) begin
            trial            = {rem_ff[k][l], low_ff[k][l][QW-1-k]};
            diff             = trial - {1'b0, divisor};
            ge               = trial >= {1'b0, divisor};
            rem_in[k+1][l]   = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            quo_in[k+1][l]   = {quo_ff[k][l][QW-2:0], ge};
            low_in[k+1][l]   = low_ff[k][l];
            over_in[k+1][l]  = over_ff[k][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
      over_ff <= over_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quo_ff  <= quo_in;
   end

   assign out_valid    = valid_ff[QW];
   assign out_side     = side_ff[QW];
   assign out_over     = over_ff[QW];
   assign out_quotient = quo_ff[QW];

endmodule

`default_nettype wire

// ===== hw/rtl/joystick_differential_drive_mixer_top.sv =====
// Top level of the joystick differential drive mixer: input prep, steering divider,
// mix multipliers, shared drive/group divider, clamp and output stage.
// Depends on jddm_pkg, jddm_csr, jddm_div.
//
// Usage:
//  - Input channel: a word (four 16-bit axes) is taken at each rising edge where
//    start is high and busy is low. busy stays low, so one word per cycle.
//  - Result channel: every word gives exactly one result word. rsp_valid is high for
//    one cycle when the word leaves the output register; the result is taken at the edge
//    that ends that cycle. The receiver cannot stall, so nothing here waits on it.
//  - Throughput: one word per cycle. The pipeline is the two 18-stage restoring
//    dividers (steering, then drive/group) plus six other stages: 42 registers in
//    all, the first loaded at the accepting edge.
//  - csr channel: csr_ready is always high; index 0 centre, 1 drive max, 2 drive min,
//    3 spin threshold. Write only while no word is in flight; the live values feed
//    the whole pipeline.
//  - Reset (synchronous, high) restores the register defaults and drops every
//    in-flight word; there is no clearing pass, the block takes words right after.
//  - Individual mode (Z or R off centre): groups come out of the second divider,
//    drives read zero. Otherwise the second divider does the mix and groups read zero.
`default_nettype none

module joystick_differential_drive_mixer_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // input channel
   input  wire logic                                   start,
   output      logic                                   busy,
   input  wire logic [jddm_pkg::AXIS_W-1:0]            req_x_axis,
   input  wire logic [jddm_pkg::AXIS_W-1:0]            req_y_axis,
   input  wire logic [jddm_pkg::AXIS_W-1:0]            req_z_axis,
   input  wire logic [jddm_pkg::AXIS_W-1:0]            req_r_axis,
   // configuration
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [jddm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [jddm_pkg::CSR_DATA_W-1:0]        csr_wdata,
   // result channel
   output      logic                                   rsp_valid,
   output      logic                                   rsp_individual_mode,
   output      logic signed [jddm_pkg::DRV_W-1:0]      rsp_left_drive,
   output      logic signed [jddm_pkg::DRV_W-1:0]      rsp_right_drive,
   output      logic signed [jddm_pkg::DRV_W-1:0]      rsp_group_one_drive,
   output      logic signed [jddm_pkg::DRV_W-1:0]      rsp_group_two_drive
);

   localparam int AW    = jddm_pkg::AXIS_W;
   localparam int DRW   = jddm_pkg::DRV_W;
   localparam int PW    = jddm_pkg::PROD_W;
   localparam int DW    = jddm_pkg::DIVD_W;
   localparam int QW    = jddm_pkg::QUO_W;
   localparam int FW    = jddm_pkg::FRAC_W;
   localparam int MIX_W = DW + FW;     // (1 +/- S) * |dy| * dmax
   localparam int RAW_W = QW + 1;      // signed pre-clamp drive

   localparam logic signed [DRW-1:0] POS_SAT = {1'b0, {(DRW-1){1'b1}}};
   localparam logic signed [DRW-1:0] NEG_SAT = {1'b1, {(DRW-1){1'b0}}};
   localparam logic [QW-1:0]         ONE_Q15 = QW'(1) << FW;

   typedef struct packed {
      logic          indiv;
      logic          neg_x;
      logic          neg_y;
      logic          neg_r;
      logic          neg_z;
      logic [PW-1:0] py;     // |dy| * dmax
      logic [PW-1:0] pr;     // |dr| * dmax
      logic [PW-1:0] pz;     // |dz| * dmax
      logic [PW-1:0] pthr;   // threshold * centre
   } side1_type;

   typedef struct packed {
      logic          indiv;
      logic          spin;
      logic          neg_y;
      logic          neg_r;
      logic          neg_z;
      logic          steer_neg;
      logic [AW-1:0] spin_mag;   // trunc(|S| * dmax / 2^15)
   } side2_type;

   //----------------------------------------------------------------------
   // helpers
   //----------------------------------------------------------------------
   function automatic logic signed [DRW-1:0] sat16(input logic neg, input logic over,
                                                   input logic [QW-1:0] mag);
      logic signed [DRW-1:0] res;
      if (!neg) begin
         res = (over || mag > QW'(POS_SAT)) ? POS_SAT : DRW'(mag);
      end else begin
         res = (over || mag > ONE_Q15) ? NEG_SAT : DRW'(QW'(0) - mag);
      end
      return res;
   endfunction

   function automatic logic signed [RAW_W-1:0] signed_mag(input logic neg, input logic over,
                                                          input logic [QW-1:0] mag);
      logic signed [RAW_W-1:0] m;
      m = over ? signed'({1'b0, {QW{1'b1}}}) : signed'({1'b0, mag});
      return neg ? -m : m;
   endfunction

   //----------------------------------------------------------------------
   // configuration
   //----------------------------------------------------------------------
   jddm_pkg::cfg_type cfg;

   jddm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   //----------------------------------------------------------------------
   // stage A: offsets from centre as sign and magnitude
   //----------------------------------------------------------------------
   logic          a_valid_ff;
   logic          a_indiv_ff, a_indiv_in;
   logic          a_neg_x_ff, a_neg_y_ff, a_neg_z_ff, a_neg_r_ff;
   logic          a_neg_x_in, a_neg_y_in, a_neg_z_in, a_neg_r_in;
   logic [AW-1:0] a_mag_x_ff, a_mag_y_ff, a_mag_z_ff, a_mag_r_ff;
   logic [AW-1:0] a_mag_x_in, a_mag_y_in, a_mag_z_in, a_mag_r_in;

   always_comb begin
      a_neg_x_in = req_x_axis < cfg.centre;
      a_neg_y_in = req_y_axis < cfg.centre;
      a_neg_z_in = req_z_axis < cfg.centre;
      a_neg_r_in = req_r_axis < cfg.centre;
      a_mag_x_in = a_neg_x_in ? cfg.centre - req_x_axis : req_x_axis - cfg.centre;
      a_mag_y_in = a_neg_y_in ? cfg.centre - req_y_axis : req_y_axis - cfg.centre;
      a_mag_z_in = a_neg_z_in ? cfg.centre - req_z_axis : req_z_axis - cfg.centre;
      a_mag_r_in = a_neg_r_in ? cfg.centre - req_r_axis : req_r_axis - cfg.centre;
      a_indiv_in = (req_z_axis != cfg.centre) || (req_r_axis != cfg.centre);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      a_indiv_ff <= a_indiv_in;
      a_neg_x_ff <= a_neg_x_in;
      a_neg_y_ff <= a_neg_y_in;
      a_neg_z_ff <= a_neg_z_in;
      a_neg_r_ff <= a_neg_r_in;
      a_mag_x_ff <= a_mag_x_in;
      a_mag_y_ff <= a_mag_y_in;
      a_mag_z_ff <= a_mag_z_in;
      a_mag_r_ff <= a_mag_r_in;
   end

   //----------------------------------------------------------------------
   // stage B: gain products and the spin-test products
   //----------------------------------------------------------------------
   logic          b_valid_ff;
   logic [AW-1:0] b_mag_x_ff;
   side1_type     b_side_ff, b_side_in;

   always_comb begin
      b_side_in.indiv = a_indiv_ff;
      b_side_in.neg_x = a_neg_x_ff;
      b_side_in.neg_y = a_neg_y_ff;
      b_side_in.neg_r = a_neg_r_ff;
      b_side_in.neg_z = a_neg_z_ff;
      b_side_in.py    = PW'(a_mag_y_ff) * PW'(cfg.drive_max);
      b_side_in.pr    = PW'(a_mag_r_ff) * PW'(cfg.drive_max);
      b_side_in.pz    = PW'(a_mag_z_ff) * PW'(cfg.drive_max);
      b_side_in.pthr  = PW'(cfg.spin_thr) * PW'(cfg.centre);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_mag_x_ff <= a_mag_x_ff;
      b_side_ff  <= b_side_in;
   end

   //----------------------------------------------------------------------
   // steering divider: |dx| * 2^15 / centre
   //----------------------------------------------------------------------
   logic [0:0][DW-1:0]            d1_dividend;
   logic                          d1_valid;
   logic [0:0][QW-1:0]            d1_quo;
   logic [0:0]                    d1_over;
   logic [$bits(side1_type)-1:0]  d1_side_raw;
   side1_type                     d1_side;

   assign d1_dividend[0] = {1'b0, b_mag_x_ff, {FW{1'b0}}};

   jddm_div #(
      .LANES  (1),
      .SIDE_W ($bits(side1_type))
   ) u_div_steer (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (b_valid_ff),
      .in_dividend  (d1_dividend),
      .divisor      (cfg.centre),
      .in_side      (b_side_ff),
      .out_valid    (d1_valid),
      .out_quotient (d1_quo),
      .out_over     (d1_over),
      .out_side     (d1_side_raw)
   );

   assign d1_side = side1_type'(d1_side_raw);

   //----------------------------------------------------------------------
   // stage C: Q1.15 steering saturation, spin test
   //----------------------------------------------------------------------
   logic                  c_valid_ff;
   logic signed [DRW-1:0] c_steer_ff;
   logic                  c_spin_ff, c_indiv_ff, c_neg_y_ff, c_neg_r_ff, c_neg_z_ff;
   logic [PW-1:0]         c_py_ff, c_pr_ff, c_pz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      c_steer_ff <= sat16(d1_side.neg_x, d1_over[0], d1_quo[0]);
      c_spin_ff  <= d1_side.py < d1_side.pthr;
      c_indiv_ff <= d1_side.indiv;
      c_neg_y_ff <= d1_side.neg_y;
      c_neg_r_ff <= d1_side.neg_r;
      c_neg_z_ff <= d1_side.neg_z;
      c_py_ff    <= d1_side.py;
      c_pr_ff    <= d1_side.pr;
      c_pz_ff    <= d1_side.pz;
   end

   //----------------------------------------------------------------------
   // stage D: (1 +/- S) * |dy| * dmax, and the spin drive
   //----------------------------------------------------------------------
   logic [AW-1:0]      d_wl;          // 2^15 + S, offset binary
   logic [QW-1:0]      d_wr;          // 2^15 - S, 1 .. 2^16
   logic [MIX_W:0]     d_kr_full;
   logic [AW-1:0]      d_abs_s;
   logic [PW-1:0]      d_sp_full;
   logic [MIX_W-1:0]   d_kl_in, d_kr_in;

   always_comb begin
      d_wl      = {~c_steer_ff[DRW-1], c_steer_ff[DRW-2:0]};
      d_wr      = ONE_Q15 - {c_steer_ff[DRW-1], c_steer_ff};
      d_kl_in   = MIX_W'(d_wl) * MIX_W'(c_py_ff);
      d_kr_full = (MIX_W+1)'(d_wr) * (MIX_W+1)'(c_py_ff);
      d_kr_in   = d_kr_full[MIX_W-1:0];
      d_abs_s   = c_steer_ff[DRW-1] ? AW'(-c_steer_ff) : AW'(c_steer_ff);
      d_sp_full = PW'(d_abs_s) * PW'(cfg.drive_max);
   end

   logic               d_valid_ff;
   logic [MIX_W-1:0]   d_kl_ff, d_kr_ff;
   logic [PW-1:0]      d_pr_ff, d_pz_ff;
   side2_type          d_side_ff, d_side_in;

   always_comb begin
      d_side_in.indiv     = c_indiv_ff;
      d_side_in.spin      = c_spin_ff;
      d_side_in.neg_y     = c_neg_y_ff;
      d_side_in.neg_r     = c_neg_r_ff;
      d_side_in.neg_z     = c_neg_z_ff;
      d_side_in.steer_neg = c_steer_ff[DRW-1];
      d_side_in.spin_mag  = AW'(d_sp_full >> FW);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_kl_ff   <= d_kl_in;
      d_kr_ff   <= d_kr_in;
      d_pr_ff   <= c_pr_ff;
      d_pz_ff   <= c_pz_ff;
      d_side_ff <= d_side_in;
   end

   //----------------------------------------------------------------------
   // shared divider: groups in individual mode, left/right mix otherwise
   //----------------------------------------------------------------------
   logic [1:0][DW-1:0]            d2_dividend;
   logic                          d2_valid;
   logic [1:0][QW-1:0]            d2_quo;
   logic [1:0]                    d2_over;
   logic [$bits(side2_type)-1:0]  d2_side_raw;
   side2_type                     d2_side;

   // mix divides by 2^15 * centre: drop 15 bits, then divide by centre
   assign d2_dividend[0] = d_side_ff.indiv ? DW'(d_pr_ff) : d_kl_ff[MIX_W-1:FW];
   assign d2_dividend[1] = d_side_ff.indiv ? DW'(d_pz_ff) : d_kr_ff[MIX_W-1:FW];

   jddm_div #(
      .LANES  (2),
      .SIDE_W ($bits(side2_type))
   ) u_div_drive (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (d_valid_ff),
      .in_dividend  (d2_dividend),
      .divisor      (cfg.centre),
      .in_side      (d_side_ff),
      .out_valid    (d2_valid),
      .out_quotient (d2_quo),
      .out_over     (d2_over),
      .out_side     (d2_side_raw)
   );

   assign d2_side = side2_type'(d2_side_raw);

   //----------------------------------------------------------------------
   // stage E: signed pre-clamp drives, saturated groups
   //----------------------------------------------------------------------
   logic                    e_valid_ff;
   logic                    e_indiv_ff;
   logic signed [DRW-1:0]   e_g1_ff, e_g2_ff;
   logic signed [RAW_W-1:0] e_lraw_ff, e_rraw_ff;
   logic signed [RAW_W-1:0] e_spin_r, e_lraw_in, e_rraw_in;

   always_comb begin
      e_spin_r = signed'({2'b00, d2_side.spin_mag});
      if (d2_side.steer_neg) begin
         e_spin_r = -e_spin_r;
      end
      if (d2_side.spin) begin
         // turn in place: left is the negated right before clamping
         e_lraw_in = -e_spin_r;
         e_rraw_in = e_spin_r;
      end else begin
         e_lraw_in = signed_mag(d2_side.neg_y, d2_over[0], d2_quo[0]);
         e_rraw_in = signed_mag(d2_side.neg_y, d2_over[1], d2_quo[1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      e_indiv_ff <= d2_side.indiv;
      e_g1_ff    <= sat16(d2_side.neg_r, d2_over[0], d2_quo[0]);
      e_g2_ff    <= sat16(d2_side.neg_z, d2_over[1], d2_quo[1]);
      e_lraw_ff  <= e_lraw_in;
      e_rraw_ff  <= e_rraw_in;
   end

   //----------------------------------------------------------------------
   // stage F: clamp to [min, max] (max wins when crossed), negate left, output
   //----------------------------------------------------------------------
   logic signed [RAW_W-1:0] f_dmin, f_dmax, f_lt, f_rt;
   logic signed [DRW-1:0]   f_left, f_right;

   always_comb begin
      f_dmin = RAW_W'(cfg.drive_min);
      f_dmax = signed'(RAW_W'(cfg.drive_max));
      f_lt   = (e_lraw_ff < f_dmin) ? f_dmin : e_lraw_ff;
      f_lt   = (f_lt > f_dmax) ? f_dmax : f_lt;
      f_rt   = (e_rraw_ff < f_dmin) ? f_dmin : e_rraw_ff;
      f_rt   = (f_rt > f_dmax) ? f_dmax : f_rt;
      f_right = f_rt[DRW-1:0];
      f_left  = (f_lt[DRW-1:0] == NEG_SAT) ? POS_SAT : -f_lt[DRW-1:0];
   end

   logic                  rsp_valid_ff;
   logic                  rsp_indiv_ff;
   logic signed [DRW-1:0] rsp_left_ff, rsp_right_ff, rsp_g1_ff, rsp_g2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_indiv_ff <= e_indiv_ff;
      rsp_left_ff  <= e_indiv_ff ? '0 : f_left;
      rsp_right_ff <= e_indiv_ff ? '0 : f_right;
      rsp_g1_ff    <= e_indiv_ff ? e_g1_ff : '0;
      rsp_g2_ff    <= e_indiv_ff ? e_g2_ff : '0;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_individual_mode = rsp_indiv_ff;
   assign rsp_left_drive      = rsp_left_ff;
   assign rsp_right_drive     = rsp_right_ff;
   assign rsp_group_one_drive = rsp_g1_ff;
   assign rsp_group_two_drive = rsp_g2_ff;

endmodule

`default_nettype wire
